// File: rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, sizes and the selection rule for the priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int SLOT_W    = $clog2(MAX_PROCS);
  localparam int COUNT_W   = $clog2(MAX_PROCS + 1);
  localparam int TIME_W    = 24;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  proc_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [7:0]  priority_level;
  } req_t;

  typedef struct packed {
    logic              load_rejected;
    logic              busy_res;
    logic [7:0]        ran_id;
    logic [TIME_W-1:0] now;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
  } rsp_t;

  // one table entry, 64 bits
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } entry_t;

  // entry coming back from the table during a scan
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    entry_t            entry;
  } cand_t;

  // current winner of a scan
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    entry_t            entry;
  } best_t;

  // a wins over b: higher priority, then earlier arrival, shorter burst, lower id
  function automatic logic beats(input entry_t a, input entry_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = (a.prio > b.prio);
    end else if (a.arrival != b.arrival) begin
      r = (a.arrival < b.arrival);
    end else if (a.burst != b.burst) begin
      r = (a.burst < b.burst);
    end else begin
      r = (a.id < b.id);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pps_table_ram.sv
// ----------------------------------------------------------------------------
// pps_table_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pps_table_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/pps_pick.sv
// ----------------------------------------------------------------------------
// pps_pick
// Running winner of a table scan: one candidate compared per cycle.
// ----------------------------------------------------------------------------
module pps_pick (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clear,
  input  pps_pkg::cand_t                  cand,
  input  logic [pps_pkg::MAX_PROCS-1:0]   finished_mask,
  input  logic [pps_pkg::TIME_W-1:0]      clock_time,
  output pps_pkg::best_t                  best
);

  import pps_pkg::*;

  logic eligible;

  // arrived and not finished
  assign eligible = cand.valid && !finished_mask[cand.slot]
                 && (TIME_W'(cand.entry.arrival) <= clock_time);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best.found <= 1'b0;
    end else if (eligible && (!best.found || beats(cand.entry, best.entry))) begin
      best.found <= 1'b1;
      best.slot  <= cand.slot;
      best.entry <= cand.entry;
    end
  end

endmodule

// File: rtl/core/preemptive_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Priority scheduler with a RAM process table and a sequential pick scan.
// ----------------------------------------------------------------------------
// A load item stores a process (id, arrival, burst, priority) in the next free
// table slot, without a scan; a full table rejects it. A tick item scans the
// loaded slots one per cycle through the table RAM's read port, keeps the best
// arrived, unfinished process (highest priority, then earlier arrival, shorter
// burst, lower id, lower slot), runs it for one time unit and writes its
// remaining time back. One item is worked on at a time; the result waits in an
// output register, and the next item is taken as soon as the result has been
// handed over to that register. The time counter saturates at 2^24-1.
// Finishing processes report turnaround and waiting times; all_done flags that
// every loaded process has completed.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pps_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pps_pkg::rsp_t rsp
);

  import pps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  state_t state;

  // architectural state
  logic [MAX_PROCS-1:0] finished_mask;
  logic [COUNT_W-1:0]   entry_count;
  logic [TIME_W-1:0]    clock_time;

  // scan control
  logic [COUNT_W-1:0]   scan_idx;
  logic                 cand_valid;
  logic [SLOT_W-1:0]    cand_slot;
  cand_t                cand;
  best_t                best;
  logic                 pick_clear;

  // result under construction
  rsp_t                 res;
  logic [15:0]          res_burst;
  rsp_t                 res_start;
  rsp_t                 res_next;
  rsp_t                 rsp_next;
  logic                 rsp_fill;

  // table RAM ports
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [SLOT_W-1:0]    ram_raddr;
  entry_t               ram_rdata;

  // derived values
  logic                 accept;
  logic                 table_full;
  logic [15:0]          rem_next;
  logic                 run_done;
  logic [TIME_W-1:0]    clock_next;
  logic [TIME_W-1:0]    wait_val;
  logic [MAX_PROCS-1:0] done_vec;
  logic                 all_done;

  assign req_ready  = (state == ST_IDLE);
  assign accept     = req_valid && req_ready;
  assign table_full = (entry_count == COUNT_W'(MAX_PROCS));
  assign pick_clear = accept && (req.req_type == REQ_TICK);

  // issue reads while slots remain; scan order is slot order
  assign ram_re    = (state == ST_SCAN) && (scan_idx < entry_count);
  assign ram_raddr = scan_idx[SLOT_W-1:0];

  // the selected process runs one time unit
  assign rem_next   = (best.entry.remaining != 16'd0) ? best.entry.remaining - 16'd1
                                                      : 16'd0;
  assign run_done   = (rem_next == 16'd0);
  assign clock_next = (clock_time == TIME_MAX) ? clock_time : clock_time + TIME_W'(1);

  // waiting is floored at zero when a saturated clock squeezes the turnaround
  assign wait_val = (res.turnaround >= TIME_W'(res_burst))
                  ? res.turnaround - TIME_W'(res_burst) : '0;

  // a slot counts as done if finished or never loaded
  always_comb begin
    for (int k = 0; k < MAX_PROCS; k++) begin
      done_vec[k] = finished_mask[k] | ~(COUNT_W'(k) < entry_count);
    end
  end
  assign all_done = &done_vec;

  // result on acceptance, after the run step, and as handed to the output
  always_comb begin
    res_start               = '0;
    res_start.now           = clock_time;
    res_start.load_rejected = (req.req_type == REQ_LOAD) && table_full;

    res_next     = res;
    res_next.now = clock_next;
    if (best.found) begin
      res_next.busy_res = 1'b1;
      res_next.ran_id   = best.entry.id;
      if (run_done) begin
        res_next.finished   = 1'b1;
        res_next.turnaround = clock_next - TIME_W'(best.entry.arrival);
      end
    end

    rsp_next          = res;
    rsp_next.waiting  = res.finished ? wait_val : '0;
    rsp_next.all_done = all_done;
  end

  // load the output register once it is free
  assign rsp_fill = (state == ST_RESP) && (!rsp_valid || rsp_ready);

  // Table writes: a load fills the next free slot, an update writes back the
  // winner. Scan reads and write-back never overlap, so no forwarding is needed.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best.slot;
    ram_wdata = best.entry;
    ram_wdata.remaining = rem_next;
    if (accept && (req.req_type == REQ_LOAD) && !table_full) begin
      ram_we              = 1'b1;
      ram_waddr           = entry_count[SLOT_W-1:0];
      ram_wdata.id        = req.proc_id;
      ram_wdata.arrival   = req.arrival_time;
      ram_wdata.burst     = req.burst_time;
      ram_wdata.prio      = req.priority_level;
      ram_wdata.remaining = req.burst_time;
    end else if ((state == ST_UPDATE) && best.found) begin
      ram_we = 1'b1;
    end
  end

  pps_table_ram #(
    .DEPTH (MAX_PROCS),
    .WIDTH ($bits(entry_t))
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cand = '{valid: cand_valid, slot: cand_slot, entry: ram_rdata};

  pps_pick u_pick (
    .clk           (clk),
    .rst           (rst),
    .clear         (pick_clear),
    .cand          (cand),
    .finished_mask (finished_mask),
    .clock_time    (clock_time),
    .best          (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      finished_mask <= '0;
      entry_count   <= '0;
      clock_time    <= '0;
      scan_idx      <= '0;
      cand_valid    <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      // raise valid on a new result, drop it once taken
      if (rsp_fill) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      // read data of this cycle belongs to the slot addressed last cycle
      cand_valid <= ram_re;
      cand_slot  <= ram_raddr;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res <= res_start;
            if (req.req_type == REQ_LOAD) begin
              if (!table_full) begin
                finished_mask[entry_count[SLOT_W-1:0]] <= (req.burst_time == 16'd0);
                entry_count <= entry_count + COUNT_W'(1);
              end
              state <= ST_RESP;
            end else begin
              scan_idx <= '0;
              state    <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          if (ram_re) begin
            scan_idx <= scan_idx + COUNT_W'(1);
          end else if (!cand_valid) begin
            state <= ST_UPDATE;
          end
        end

        ST_UPDATE: begin
          clock_time <= clock_next;
          res        <= res_next;
          res_burst  <= best.entry.burst;
          if (best.found && run_done) begin
            finished_mask[best.slot] <= 1'b1;
          end
          state <= ST_RESP;
        end

        ST_RESP: begin
          // hold until the output register is free
          if (rsp_fill) begin
            rsp   <= rsp_next;
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/pps_sched_check.sv
// ----------------------------------------------------------------------------
// pps_sched_check
// Watches both channels of the priority scheduler and checks every result.
// ----------------------------------------------------------------------------
// Every accepted request is run through a local schedule predictor that keeps
// its own process table. The expected result goes into an in-order queue.
// Every accepted result is compared with the oldest expectation, one field at
// a time.
// ----------------------------------------------------------------------------
module pps_sched_check (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  pps_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  pps_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending,
  output int            completions
);
  import pps_pkg::*;

  // predictor state
  entry_t               proc_slots [MAX_PROCS];
  logic [MAX_PROCS-1:0] done_mask;
  int                   n_loaded;
  logic [TIME_W-1:0]    sim_clock;

  rsp_t due_rsp [$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    completions = 0;
    done_mask   = '0;
    n_loaded    = 0;
    sim_clock   = '0;
  end

  function automatic logic outranks(input entry_t a, input entry_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    if (a.arrival != b.arrival) return a.arrival < b.arrival;
    if (a.burst != b.burst) return a.burst < b.burst;
    return a.id < b.id;
  endfunction

  function automatic logic all_finished();
    for (int k = 0; k < n_loaded; k++) begin
      if (!done_mask[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // apply one request to the predictor and return the result it owes
  function automatic rsp_t schedule_step(input req_t r);
    rsp_t              o;
    int                pick;
    logic [TIME_W-1:0] tat;
    o = '0;
    if (r.req_type == REQ_LOAD) begin
      if (n_loaded >= MAX_PROCS) begin
        o.load_rejected = 1'b1;
      end else begin
        proc_slots[n_loaded].id        = r.proc_id;
        proc_slots[n_loaded].arrival   = r.arrival_time;
        proc_slots[n_loaded].burst     = r.burst_time;
        proc_slots[n_loaded].prio      = r.priority_level;
        proc_slots[n_loaded].remaining = r.burst_time;
        done_mask[n_loaded] = (r.burst_time == 16'd0);
        n_loaded++;
      end
      o.now      = sim_clock;
      o.all_done = all_finished();
      return o;
    end
    // scan in slot order; a strict win is needed, so the lower slot keeps a full tie
    pick = -1;
    for (int k = 0; k < n_loaded; k++) begin
      if (!done_mask[k] && TIME_W'(proc_slots[k].arrival) <= sim_clock) begin
        if (pick < 0 || outranks(proc_slots[k], proc_slots[pick])) pick = k;
      end
    end
    if (sim_clock != TIME_MAX) sim_clock++;
    o.now = sim_clock;
    if (pick >= 0) begin
      o.busy_res = 1'b1;
      o.ran_id   = proc_slots[pick].id;
      if (proc_slots[pick].remaining != 0) proc_slots[pick].remaining--;
      if (proc_slots[pick].remaining == 0) begin
        tat = sim_clock - TIME_W'(proc_slots[pick].arrival);
        done_mask[pick] = 1'b1;
        o.finished      = 1'b1;
        o.turnaround    = tat;
        o.waiting       = (tat >= TIME_W'(proc_slots[pick].burst)) ?
                          tat - TIME_W'(proc_slots[pick].burst) : '0;
        completions++;
      end
    end
    o.all_done = all_finished();
    return o;
  endfunction

  task automatic check_field(input string fname, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      // compare first: a result never belongs to a request taken at the same edge
      if (rsp_valid && rsp_ready) begin
        if (due_rsp.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual %p", $time, rsp);
        end else begin
          want = due_rsp.pop_front();
          check_field("load_rejected", want.load_rejected, rsp.load_rejected);
          check_field("busy_res", want.busy_res, rsp.busy_res);
          check_field("ran_id", want.ran_id, rsp.ran_id);
          check_field("now", want.now, rsp.now);
          check_field("finished", want.finished, rsp.finished);
          check_field("turnaround", want.turnaround, rsp.turnaround);
          check_field("waiting", want.waiting, rsp.waiting);
          check_field("all_done", want.all_done, rsp.all_done);
        end
      end
      if (req_valid && req_ready) due_rsp.push_back(schedule_step(req));
      pending = due_rsp.size();
    end
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
// A directed opening covers an empty table, tie breaks on burst, id and slot,
// a zero burst, a process that never arrives, a late arrival and preemption.
// The random part spreads the remaining loads over the run and fills the table,
// then mixes mostly ticks with loads that must be rejected. Both sides idle
// and stall at random in changing amounts. Checking is done in pps_sched_check.
// ----------------------------------------------------------------------------
module tb;
  import pps_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int N_ITEMS    = 1250;
  localparam int DRAIN_CYC  = 64;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count;
  int pending;
  int completions;

  // pacing: percent of cycles the sender idles and the receiver stalls
  int idle_pct  = 27;
  int stall_pct = 68;

  int items_sent = 0;
  int ticks_sent = 0;
  int loads_sent = 0;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  preemptive_priority_scheduler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  pps_sched_check checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .pending     (pending),
    .completions (completions)
  );

  // Stall the result side at the current rate; hold ready low through reset.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic req_t mk_load(input logic [7:0] id, input logic [15:0] arr,
                                   input logic [15:0] burst, input logic [7:0] prio);
    req_t r;
    r.req_type       = REQ_LOAD;
    r.proc_id        = id;
    r.arrival_time   = arr;
    r.burst_time     = burst;
    r.priority_level = prio;
    return r;
  endfunction

  // Fill the ignored fields of a tick with noise so the block must not use them.
  function automatic req_t mk_tick();
    req_t r;
    r.req_type       = REQ_TICK;
    r.proc_id        = 8'($urandom);
    r.arrival_time   = 16'($urandom);
    r.burst_time     = 16'($urandom);
    r.priority_level = 8'($urandom);
    return r;
  endfunction

  // Send one item. Pick the pacing for the current third of the run, idle for
  // a random stretch, then hold valid and payload until the item is taken.
  // Each step sees a single assignment to valid, so back-to-back items keep it
  // high.
  task automatic send_item(input req_t item);
    if (items_sent < N_ITEMS / 3) begin
      idle_pct  = 27;
      stall_pct = 68;
    end else if (items_sent < 2 * N_ITEMS / 3) begin
      idle_pct  = 68;
      stall_pct = 27;
    end else begin
      idle_pct  = 0;
      stall_pct = 0;
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
    if (item.req_type == REQ_TICK) ticks_sent++;
    else loads_sent++;
  endtask

  initial begin
    logic [15:0] arr;
    logic [7:0]  prio;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed opening ---
    // Tick an empty table: idle, and everything counts as done.
    send_item(mk_tick());
    // Run a single top priority, one-unit process to completion.
    send_item(mk_load(8'd255, 16'd0, 16'd1, 8'd255));
    send_item(mk_tick());
    // Store a zero burst process: it starts finished and never runs.
    send_item(mk_load(8'd0, 16'd0, 16'd0, 8'd0));
    // Equal priority and arrival: shorter burst first, then lower id.
    send_item(mk_load(8'd7, 16'd0, 16'd3, 8'd200));
    send_item(mk_load(8'd3, 16'd0, 16'd1, 8'd200));
    send_item(mk_load(8'd5, 16'd0, 16'd3, 8'd200));
    // Duplicate of the previous entry: the lower slot takes the full tie.
    send_item(mk_load(8'd5, 16'd0, 16'd3, 8'd200));
    // Arrives at the last representable time: stays waiting for the whole run.
    send_item(mk_load(8'd9, 16'hFFFF, 16'hFFFF, 8'd255));
    // Arrives at time 2 with a higher priority and preempts the running job.
    send_item(mk_load(8'd20, 16'd2, 16'd2, 8'd201));
    repeat (6) send_item(mk_tick());
    // Late arrival: its arrival lies before the clock, so it is ready at once.
    send_item(mk_load(8'd30, 16'd1, 16'd2, 8'd254));
    repeat (4) send_item(mk_tick());

    // --- random part ---
    while (items_sent < N_ITEMS) begin
      if (loads_sent < MAX_PROCS &&
          ($urandom_range(0, 79) == 0 || items_sent >= N_ITEMS - 200)) begin
        // Spread the free slots over the run; arrival near the clock, either
        // already past or a little ahead, and priorities that often tie.
        if ($urandom_range(0, 1) == 1) begin
          arr = 16'($urandom_range(0, ticks_sent));
        end else begin
          arr = 16'(ticks_sent + $urandom_range(0, 30));
        end
        prio = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(250, 255)) :
                                              8'($urandom_range(0, 255));
        send_item(mk_load(8'($urandom_range(0, 255)), arr,
                          16'($urandom_range(1, 40)), prio));
      end else if (loads_sent >= MAX_PROCS && $urandom_range(0, 9) == 0) begin
        // Table is full: any load must come back rejected.
        send_item(mk_load(8'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
                          8'($urandom)));
      end else begin
        send_item(mk_tick());
      end
    end
    req_valid <= 1'b0;

    // Drain: wait for the last results, then watch for strays a while longer.
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Drove %0d items: %0d ticks and %0d loads, %0d of them past a full table.",
             items_sent, ticks_sent, loads_sent,
             (loads_sent > MAX_PROCS) ? loads_sent - MAX_PROCS : 0);
    $display("Saw %0d process completions across all three pacing phases.", completions);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(CLK_PERIOD * 600000);
    $display("Timeout with %0d results outstanding", pending);
    $display("Verification failed");
    $finish;
  end

endmodule
